### hdl/sphere_contact_proxy_force_macros.svh
// ----------------------------------------------------------------------------
// Sphere contact proxy force assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SPHERE_CONTACT_PROXY_FORCE_MACROS_SVH
`define SPHERE_CONTACT_PROXY_FORCE_MACROS_SVH

// same-cycle implication
`define SCPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/scpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere contact proxy force package
// Register layout, fixed field widths and the lane command set.
// ----------------------------------------------------------------------------
package scpf_pkg;

  localparam int unsigned RADIUS_W   = 14;
  localparam int unsigned STIFF_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 14'd5120;
  localparam logic [STIFF_W-1:0]  STIFF_RST  = 16'd6554;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STIFF  = 2'd1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_MR_LD,
    OP_DIV_LD,
    OP_DIV,
    OP_PRX,
    OP_FLD,
    OP_FRC,
    OP_PASS
  } scpf_op_e;

  typedef struct packed {
    scpf_op_e              op;
    logic [RADIUS_W-1:0]   radius;
    logic [STIFF_W-1:0]    stiff;
  } scpf_lane_ctl_t;

endpackage

### hdl/sphere_contact_proxy_force.sv
`timescale 1ns / 1ps
`include "sphere_contact_proxy_force_macros.svh"
// ----------------------------------------------------------------------------
// Sphere contact proxy force
// Projects the stylus onto the contact sphere and forms the spring force.
//
//   channel  handshake                  payload
//   in       in_valid_i / in_stall_o    pos_x_i, pos_y_i, pos_z_i
//   out      out_valid_o / out_stall_i  proxy_*_o, force_*_o, in_contact_o
//   cfg      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A contact item passes through the serial squares, the one-bit-per-cycle
// root, the radius product, the 14-step divide and the stiffness product. An
// item outside contact stops after the root and compare; an all-zero position
// skips straight to done. Reset loads the register defaults and clears
// the held result. A finished result sits in the output register; a stalled
// output holds the next result in the lanes until the register frees.
// ----------------------------------------------------------------------------
module sphere_contact_proxy_force #(
  parameter int unsigned POSITION_BITS = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [POSITION_BITS-1:0]     pos_x_i,
  input  logic signed [POSITION_BITS-1:0]     pos_y_i,
  input  logic signed [POSITION_BITS-1:0]     pos_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [POSITION_BITS-1:0]     proxy_x_o,
  output logic signed [POSITION_BITS-1:0]     proxy_y_o,
  output logic signed [POSITION_BITS-1:0]     proxy_z_o,
  output logic signed [POSITION_BITS-1:0]     force_x_o,
  output logic signed [POSITION_BITS-1:0]     force_y_o,
  output logic signed [POSITION_BITS-1:0]     force_z_o,
  output logic                                in_contact_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [scpf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [scpf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import scpf_pkg::*;

  localparam int unsigned P    = POSITION_BITS;
  localparam int unsigned SQW  = 2 * P;
  localparam int unsigned MXW  = (P > RADIUS_W) ? P : RADIUS_W;
  localparam int unsigned CNTW = $clog2(MXW);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_ROOT = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_MR   = 4'd5;
  localparam logic [3:0] S_DLD  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_PRX  = 4'd8;
  localparam logic [3:0] S_FLD  = 4'd9;
  localparam logic [3:0] S_MF   = 4'd10;
  localparam logic [3:0] S_FRC  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]          state_q, state_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic [RADIUS_W-1:0] radius_q;
  logic [STIFF_W-1:0]  stiff_q;
  logic [SQW-1:0]      rad_q, rad_d;
  logic [P:0]          srem_q, srem_d;
  logic [P-1:0]        root_q, root_d;
  logic                zero_q, zero_d;
  logic                contact_q, contact_d;
  logic                out_valid_q, out_valid_d;
  logic                in_contact_q;
  logic [P-1:0]        held_proxy_q [3];
  logic [P-1:0]        held_force_q [3];

  logic [P-1:0]   pos_in     [3];
  logic [SQW-1:0] lane_sq    [3];
  logic [P-1:0]   lane_proxy [3];
  logic [P-1:0]   lane_force [3];
  scpf_op_e       lane_op;
  scpf_lane_ctl_t lane_ctl;

  logic           in_beat, out_load, all_zero, cnt_end;
  logic [P+2:0]   sq_sh, sq_trial;
  logic           sq_ge;
  logic [P+2:0]   sq_diff;
  logic [MXW-1:0] root_x, radius_x;

  assign pos_in[0] = pos_x_i;
  assign pos_in[1] = pos_y_i;
  assign pos_in[2] = pos_z_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_beat     = in_valid_i && !in_stall_o;
  assign all_zero    = ~|{pos_x_i, pos_y_i, pos_z_i};
  assign cnt_end     = (cnt_q == '0);
  assign cfg_ready_o = 1'b1;

  assign sq_sh    = {srem_q, rad_q[SQW-1:SQW-2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);
  assign sq_diff  = sq_sh - sq_trial;
  assign root_x   = MXW'(root_q);
  assign radius_x = MXW'(radius_q);

  assign lane_ctl.op     = lane_op;
  assign lane_ctl.radius = radius_q;
  assign lane_ctl.stiff  = stiff_q;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    scpf_lane #(
      .P (P)
    ) u_lane (
      .clk_i   (clk_i),
      .ctl_i   (lane_ctl),
      .pos_i   (pos_in[g]),
      .root_i  (root_q),
      .sq_o    (lane_sq[g]),
      .proxy_o (lane_proxy[g]),
      .force_o (lane_force[g])
    );
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rad_d     = rad_q;
    srem_d    = srem_q;
    root_d    = root_q;
    zero_d    = zero_q;
    contact_d = contact_q;
    lane_op   = OP_NONE;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          lane_op   = OP_LOAD;
          zero_d    = all_zero;
          contact_d = 1'b1;
          cnt_d     = CNTW'(P - 1);
          state_d   = all_zero ? S_DONE : S_SQ;
        end
      end
      S_SQ: begin
        lane_op = OP_MUL;
        cnt_d   = cnt_q - CNTW'(1);
        if (cnt_end) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        rad_d   = lane_sq[0] + lane_sq[1] + lane_sq[2];
        srem_d  = '0;
        root_d  = '0;
        cnt_d   = CNTW'(P - 1);
        state_d = S_ROOT;
      end
      S_ROOT: begin
        srem_d = sq_ge ? sq_diff[P:0] : sq_sh[P:0];
        root_d = {root_q[P-2:0], sq_ge};
        rad_d  = {rad_q[SQW-3:0], 2'b00};
        cnt_d  = cnt_q - CNTW'(1);
        if (cnt_end) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (root_x > radius_x) begin
          lane_op   = OP_PASS;
          contact_d = 1'b0;
          state_d   = S_DONE;
        end else begin
          lane_op = OP_MR_LD;
          cnt_d   = CNTW'(P - 1);
          state_d = S_MR;
        end
      end
      S_MR: begin
        lane_op = OP_MUL;
        cnt_d   = cnt_q - CNTW'(1);
        if (cnt_end) begin
          state_d = S_DLD;
        end
      end
      S_DLD: begin
        lane_op = OP_DIV_LD;
        cnt_d   = CNTW'(RADIUS_W - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        lane_op = OP_DIV;
        cnt_d   = cnt_q - CNTW'(1);
        if (cnt_end) begin
          state_d = S_PRX;
        end
      end
      S_PRX: begin
        lane_op = OP_PRX;
        state_d = S_FLD;
      end
      S_FLD: begin
        lane_op = OP_FLD;
        cnt_d   = CNTW'(P - 1);
        state_d = S_MF;
      end
      S_MF: begin
        lane_op = OP_MUL;
        cnt_d   = cnt_q - CNTW'(1);
        if (cnt_end) begin
          state_d = S_FRC;
        end
      end
      S_FRC: begin
        lane_op = OP_FRC;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      zero_q    <= 1'b0;
      contact_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      zero_q    <= zero_d;
      contact_q <= contact_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    srem_q <= srem_d;
    root_q <= root_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      stiff_q  <= STIFF_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_RADIUS: radius_q <= cfg_data_i[RADIUS_W-1:0];
        CFG_STIFF:  stiff_q  <= cfg_data_i[STIFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // hold the last result; an all-zero position repeats it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      in_contact_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        held_proxy_q[i] <= '0;
        held_force_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (out_load) begin
        in_contact_q <= contact_q;
        if (!zero_q) begin
          for (int i = 0; i < 3; i++) begin
            held_proxy_q[i] <= lane_proxy[i];
            held_force_q[i] <= lane_force[i];
          end
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign in_contact_o = in_contact_q;
  assign proxy_x_o    = held_proxy_q[0];
  assign proxy_y_o    = held_proxy_q[1];
  assign proxy_z_o    = held_proxy_q[2];
  assign force_x_o    = held_force_q[0];
  assign force_y_o    = held_force_q[1];
  assign force_z_o    = held_force_q[2];

  `SCPF_ASSERT_NOW(a_free_no_force, out_valid_o && !in_contact_o,
    force_x_o == '0 && force_y_o == '0 && force_z_o == '0, "force without contact")
  `SCPF_ASSERT_NXT(a_beat_busy, in_beat, in_stall_o, "accepted beat left block idle")
  `SCPF_ASSERT_NOW(a_valid_from_done, $rose(out_valid_o),
    $past(state_q == S_DONE), "result raised outside done state")
  `SCPF_ASSERT_NXT(a_zero_short, in_beat && all_zero,
    state_q == S_DONE, "zero position did not skip to done")

endmodule

### hdl/scpf_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere contact proxy force axis lane
// One coordinate: serial square, radius product, rounded divide by the
// distance, proxy saturation and serial stiffness product.
// ----------------------------------------------------------------------------
module scpf_lane #(
  parameter int unsigned P = 15
) (
  input  logic                     clk_i,
  input  scpf_pkg::scpf_lane_ctl_t ctl_i,
  input  logic [P-1:0]             pos_i,
  input  logic [P-1:0]             root_i,
  output logic [2*P-1:0]           sq_o,
  output logic [P-1:0]             proxy_o,
  output logic [P-1:0]             force_o
);
  import scpf_pkg::*;

  localparam int unsigned PW  = (P > STIFF_W) ? 2 * P : P + STIFF_W;
  localparam int unsigned DVW = P + RADIUS_W + 1;
  localparam int unsigned XW  = ((P > RADIUS_W) ? P : RADIUS_W) + 1;
  localparam int unsigned FW  = PW - STIFF_W;

  localparam logic [PW-1:0] RND     = PW'(1) << (STIFF_W - 1);
  localparam logic [XW-1:0] QLIM_P  = XW'((1 << (P - 1)) - 1);
  localparam logic [XW-1:0] QLIM_N  = XW'(1 << (P - 1));
  localparam logic [FW-1:0] FLIM_P  = FW'((1 << (P - 1)) - 1);
  localparam logic [FW-1:0] FLIM_N  = FW'(1 << (P - 1));
  localparam logic [P-1:0]  POS_MAX = {1'b0, {(P - 1){1'b1}}};
  localparam logic [P-1:0]  POS_MIN = {1'b1, {(P - 1){1'b0}}};

  logic [P-1:0]        pos_q, pos_d;
  logic [PW-1:0]       mcand_q, mcand_d;
  logic [P-1:0]        mplier_q, mplier_d;
  logic [PW-1:0]       acc_q, acc_d;
  logic [DVW-1:0]      rem_q, rem_d;
  logic [DVW-1:0]      dsh_q, dsh_d;
  logic [RADIUS_W-1:0] quo_q, quo_d;
  logic                dneg_q, dneg_d;
  logic [P-1:0]        proxy_q, proxy_d;
  logic [P-1:0]        force_q, force_d;

  logic [P-1:0]  mag_in, mag_q;
  logic [XW-1:0] qx, qneg;
  logic [P:0]    diff, dabs;
  logic [PW-1:0] rnd;
  logic [FW-1:0] fm, fneg;

  assign mag_in = pos_i[P-1] ? (~pos_i) + P'(1) : pos_i;
  assign mag_q  = pos_q[P-1] ? (~pos_q) + P'(1) : pos_q;
  assign qx     = XW'(quo_q);
  assign qneg   = (~qx) + XW'(1);
  assign diff   = {proxy_q[P-1], proxy_q} - {pos_q[P-1], pos_q};
  assign dabs   = diff[P] ? (~diff) + (P + 1)'(1) : diff;
  assign rnd    = acc_q + RND;
  assign fm     = rnd[PW-1:STIFF_W];
  assign fneg   = (~fm) + FW'(1);

  always_comb begin
    pos_d    = pos_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    dsh_d    = dsh_q;
    quo_d    = quo_q;
    dneg_d   = dneg_q;
    proxy_d  = proxy_q;
    force_d  = force_q;
    case (ctl_i.op)
      OP_LOAD: begin
        pos_d    = pos_i;
        mcand_d  = PW'(mag_in);
        mplier_d = mag_in;
        acc_d    = '0;
      end
      OP_MUL: begin
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
      end
      OP_MR_LD: begin
        mcand_d  = PW'(ctl_i.radius);
        mplier_d = mag_q;
        acc_d    = '0;
      end
      OP_DIV_LD: begin
        rem_d = {acc_q[DVW-2:0], 1'b0} + DVW'(root_i);
        dsh_d = {1'b0, root_i, RADIUS_W'(0)};
        quo_d = '0;
      end
      OP_DIV: begin
        if (rem_q >= dsh_q) begin
          rem_d = rem_q - dsh_q;
        end
        quo_d = {quo_q[RADIUS_W-2:0], rem_q >= dsh_q};
        dsh_d = dsh_q >> 1;
      end
      OP_PRX: begin
        if (pos_q[P-1]) begin
          proxy_d = (qx > QLIM_N) ? POS_MIN : qneg[P-1:0];
        end else begin
          proxy_d = (qx > QLIM_P) ? POS_MAX : qx[P-1:0];
        end
      end
      OP_FLD: begin
        dneg_d   = diff[P];
        mcand_d  = PW'(ctl_i.stiff);
        mplier_d = dabs[P-1:0];
        acc_d    = '0;
      end
      OP_FRC: begin
        if (dneg_q) begin
          force_d = (fm > FLIM_N) ? POS_MIN : fneg[P-1:0];
        end else begin
          force_d = (fm > FLIM_P) ? POS_MAX : fm[P-1:0];
        end
      end
      OP_PASS: begin
        proxy_d = pos_q;
        force_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    dsh_q    <= dsh_d;
    quo_q    <= quo_d;
    dneg_q   <= dneg_d;
    proxy_q  <= proxy_d;
    force_q  <= force_d;
  end

  assign sq_o    = acc_q[2*P-1:0];
  assign proxy_o = proxy_q;
  assign force_o = force_q;

endmodule
